// ===== rtl/core/uer_pkg.sv =====
package uer_pkg;

    localparam int COUNT_WIDTH_DEF = 20;

    localparam int TRIG_W     = 8;
    localparam int TMO_MS_W   = 10;
    localparam int LIMIT_W    = 20;
    localparam int US_PER_MS  = 1000;
    localparam int DIST_W     = 21;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_ADDR_W = 1;

    localparam logic [DIST_W-1:0]   DIST_MAX     = {DIST_W{1'b1}};
    localparam logic [TRIG_W-1:0]   TRIG_LEN_RST = 8'd10;
    localparam logic [TMO_MS_W-1:0] TMO_MS_RST   = 10'd60;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST    = LIMIT_W'(60 * US_PER_MS);

    // pulse * 256 / 148 reduced to pulse * 64 / 37, tracked one tick at a time
    localparam int REM_W       = 6;
    localparam int Q8_NUM      = 64;
    localparam int Q8_DIV      = 37;
    localparam logic [REM_W-1:0] Q8_DIV_C   = REM_W'(Q8_DIV);
    localparam logic [REM_W-1:0] Q8_REM_ADD = REM_W'(Q8_NUM - Q8_DIV);

    localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER_LEN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_MS  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_WAIT_START = 2'd1,
        PH_WAIT_END   = 2'd2,
        PH_READY      = 2'd3
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic echo_edge;
        logic read_ack;
    } tick_t;

    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_len;
        logic [LIMIT_W-1:0] timeout_limit;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic advance;
    } pulse_ctl_t;

    typedef struct packed {
        logic              trigger_out;
        logic              start_refused;
        logic              data_ready;
        logic [DIST_W-1:0] distance_q8;
        logic [1:0]        phase;
    } result_t;

endpackage

// ===== rtl/core/ultrasonic_echo_ranging.sv =====
// Ultrasonic time-of-flight ranging, one input word per microsecond tick.
// Input stream s_*: tdata[0] start_req, [1] echo_edge, [2] read_ack.
// Output stream m_*: one word per input word, the state after that tick:
//   trigger pin level, start refused, data ready, distance in Q.8 inches,
//   and phase (0 idle, 1 wait echo start, 2 wait echo end, 3 ready).
// Config port: cfg_wr_en with cfg_addr 0 = trigger length in ticks,
//   1 = timeout in ms from the accepted start. Write only while idle.
// The output word is registered from its input word. Throughput is one
// word per cycle while the receiver keeps up: the whole tick update sits
// between the state registers and the output register, and the distance
// quotient steps with the pulse counter so no divider is in the path.
// A stalled receiver holds the output word; s_tready stays high while the
// output register is empty or being taken in the same cycle.
// Reset (aresetn low, synchronous) returns to idle, clears counters and the
// stored distance, empties the output register, and restores trigger
// length 10 and timeout 60 ms.
module ultrasonic_echo_ranging #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // start_req, echo_edge, read_ack
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // trigger_out, start_refused,
                                                       // data_ready, distance_q8, phase
    input  logic                            cfg_wr_en,
    input  logic [uer_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    uer_pkg::cfg_t        cfg;
    uer_pkg::tick_t       tick;
    uer_pkg::pulse_ctl_t  pulse_ctl;
    uer_pkg::result_t     result;
    logic [COUNT_WIDTH:0] dist_q;
    logic                 tick_en;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [31:0]          m_tdata_reg, m_tdata_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign tick_en  = s_tvalid && s_tready;

    assign tick.start_req = s_tdata[0];
    assign tick.echo_edge = s_tdata[1];
    assign tick.read_ack  = s_tdata[2];

    uer_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    uer_pulse #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_pulse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (tick_en),
        .ctl     (pulse_ctl),
        .dist_q  (dist_q)
    );

    uer_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick_en   (tick_en),
        .tick      (tick),
        .cfg       (cfg),
        .dist_q    (dist_q),
        .pulse_ctl (pulse_ctl),
        .result    (result)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (tick_en) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, result.phase, result.distance_q8, result.data_ready,
                             result.start_refused, result.trigger_out};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/uer_cfg.sv =====
module uer_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [uer_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output uer_pkg::cfg_t                      cfg
);

    logic [uer_pkg::TRIG_W-1:0]  trig_len_reg, trig_len_next;
    logic [uer_pkg::LIMIT_W-1:0] limit_reg, limit_next;

    always_comb begin
        trig_len_next = trig_len_reg;
        limit_next    = limit_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                uer_pkg::CFG_TRIGGER_LEN: begin
                    trig_len_next = cfg_wdata[uer_pkg::TRIG_W-1:0];
                end
                uer_pkg::CFG_TIMEOUT_MS: begin
                    limit_next = uer_pkg::LIMIT_W'(
                        cfg_wdata[uer_pkg::TMO_MS_W-1:0] * uer_pkg::US_PER_MS);
                end
                default: begin
                    trig_len_next = trig_len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_len_reg <= uer_pkg::TRIG_LEN_RST;
            limit_reg    <= uer_pkg::LIMIT_RST;
        end else begin
            trig_len_reg <= trig_len_next;
            limit_reg    <= limit_next;
        end
    end

    assign cfg.trigger_len   = trig_len_reg;
    assign cfg.timeout_limit = limit_reg;

endmodule

// ===== rtl/core/uer_pulse.sv =====
module uer_pulse #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_en,
    input  uer_pkg::pulse_ctl_t   ctl,
    output logic [COUNT_WIDTH:0]  dist_q
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0]    pulse_reg, pulse_next;
    logic [COUNT_WIDTH:0]      q_reg, q_next, q_inc;
    logic [uer_pkg::REM_W-1:0] rem_reg, rem_next, rem_inc, rem_sum;
    logic                      step;

    // quotient and remainder of pulse * 64 / 37, stepped with the count
    always_comb begin
        step    = ctl.advance && (pulse_reg != CNT_MAX);
        rem_sum = rem_reg + uer_pkg::Q8_REM_ADD;
        q_inc   = q_reg;
        rem_inc = rem_reg;
        if (step) begin
            if (rem_sum >= uer_pkg::Q8_DIV_C) begin
                rem_inc = rem_sum - uer_pkg::Q8_DIV_C;
                q_inc   = q_reg + (COUNT_WIDTH+1)'(2);
            end else begin
                rem_inc = rem_sum;
                q_inc   = q_reg + (COUNT_WIDTH+1)'(1);
            end
        end
    end

    always_comb begin
        if (ctl.clear) begin
            pulse_next = '0;
            q_next     = '0;
            rem_next   = '0;
        end else begin
            pulse_next = step ? pulse_reg + COUNT_WIDTH'(1) : pulse_reg;
            q_next     = q_inc;
            rem_next   = rem_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg <= '0;
            q_reg     <= '0;
            rem_reg   <= '0;
        end else if (tick_en) begin
            pulse_reg <= pulse_next;
            q_reg     <= q_next;
            rem_reg   <= rem_next;
        end
    end

    assign dist_q = q_inc;

endmodule

// ===== rtl/core/uer_ctrl.sv =====
module uer_ctrl #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_en,
    input  uer_pkg::tick_t        tick,
    input  uer_pkg::cfg_t         cfg,
    input  logic [COUNT_WIDTH:0]  dist_q,
    output uer_pkg::pulse_ctl_t   pulse_ctl,
    output uer_pkg::result_t      result
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam int TMO_CMP_W  = (COUNT_WIDTH > uer_pkg::LIMIT_W) ? COUNT_WIDTH
                                                                 : uer_pkg::LIMIT_W;
    localparam int DIST_CMP_W = (COUNT_WIDTH + 1 > uer_pkg::DIST_W) ? COUNT_WIDTH + 1
                                                                    : uer_pkg::DIST_W;

    uer_pkg::phase_t                phase_reg, phase_next;
    logic [uer_pkg::TRIG_W-1:0]     trig_cnt_reg, trig_cnt_next, trig_load;
    logic [COUNT_WIDTH-1:0]         tmo_cnt_reg, tmo_cnt_next, tmo_inc;
    logic [uer_pkg::DIST_W-1:0]     dist_reg, dist_next, dist_clamped;
    logic [DIST_CMP_W-1:0]          q_ext;
    logic                           waiting, timeout_hit, start_ok, refused, trig_out;

    always_comb begin
        waiting = (phase_reg == uer_pkg::PH_WAIT_START) ||
                  (phase_reg == uer_pkg::PH_WAIT_END);
        tmo_inc = (waiting && tmo_cnt_reg != CNT_MAX) ? tmo_cnt_reg + COUNT_WIDTH'(1)
                                                      : tmo_cnt_reg;
        timeout_hit = (TMO_CMP_W'(tmo_inc) >= TMO_CMP_W'(cfg.timeout_limit)) ||
                      (tmo_inc == CNT_MAX);
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            uer_pkg::PH_IDLE: begin
                if (tick.start_req) begin
                    phase_next = uer_pkg::PH_WAIT_START;
                end
            end
            uer_pkg::PH_WAIT_START: begin
                if (timeout_hit) begin
                    phase_next = uer_pkg::PH_IDLE;
                end else if (tick.echo_edge) begin
                    phase_next = uer_pkg::PH_WAIT_END;
                end
            end
            uer_pkg::PH_WAIT_END: begin
                if (tick.echo_edge) begin
                    phase_next = uer_pkg::PH_READY;
                end else if (timeout_hit) begin
                    phase_next = uer_pkg::PH_IDLE;
                end
            end
            uer_pkg::PH_READY: begin
                if (tick.read_ack) begin
                    phase_next = uer_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = uer_pkg::PH_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        start_ok  = (phase_reg == uer_pkg::PH_IDLE) && tick.start_req;
        refused   = (phase_reg != uer_pkg::PH_IDLE) && tick.start_req;
        trig_load = start_ok ? cfg.trigger_len : trig_cnt_reg;
        trig_out  = (trig_load != '0);
        trig_cnt_next = trig_out ? trig_load - uer_pkg::TRIG_W'(1) : trig_load;
        tmo_cnt_next  = start_ok ? '0 : tmo_inc;

        pulse_ctl.clear   = (phase_reg == uer_pkg::PH_WAIT_START) && tick.echo_edge;
        pulse_ctl.advance = (phase_reg == uer_pkg::PH_WAIT_END);

        q_ext        = DIST_CMP_W'(dist_q);
        dist_clamped = (q_ext > DIST_CMP_W'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                                : q_ext[uer_pkg::DIST_W-1:0];
        dist_next    = ((phase_reg == uer_pkg::PH_WAIT_END) && tick.echo_edge) ?
                       dist_clamped : dist_reg;

        result.trigger_out   = trig_out;
        result.start_refused = refused;
        result.data_ready    = (phase_next == uer_pkg::PH_READY);
        result.distance_q8   = dist_next;
        result.phase         = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= uer_pkg::PH_IDLE;
            trig_cnt_reg <= '0;
            tmo_cnt_reg  <= '0;
            dist_reg     <= '0;
        end else if (tick_en) begin
            phase_reg    <= phase_next;
            trig_cnt_reg <= trig_cnt_next;
            tmo_cnt_reg  <= tmo_cnt_next;
            dist_reg     <= dist_next;
        end
    end

`ifndef SYNTHESIS
    a_start_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_en && phase_reg == uer_pkg::PH_IDLE && tick.start_req
        |=> phase_reg == uer_pkg::PH_WAIT_START)
        else $error("accepted start did not enter echo wait");

    a_end_edge_wins: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_en && phase_reg == uer_pkg::PH_WAIT_END && tick.echo_edge
        |=> phase_reg == uer_pkg::PH_READY)
        else $error("end edge did not make the block ready");

    a_hold_without_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !tick_en |=> $stable(phase_reg) && $stable(trig_cnt_reg) && $stable(dist_reg))
        else $error("state moved without an input word");

    a_trigger_no_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_en && phase_reg != uer_pkg::PH_IDLE
        |=> trig_cnt_reg == '0 || trig_cnt_reg < $past(trig_cnt_reg))
        else $error("trigger reloaded while busy");
`endif

endmodule

// ===== tb/sv/uer_checker.sv =====
`timescale 1ns / 100ps

module uer_checker #(
    parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // start_req, echo_edge, read_ack
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [31:0]                    m_tdata,   // trigger_out, start_refused,
                                                      // data_ready, distance_q8, phase
    input  logic                           cfg_wr_en,
    input  logic [uer_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             expect_depth
);

    localparam int DIST_SCALE  = 256;
    localparam int DIST_DIVIDE = 148;

    uer_pkg::phase_t              ph;
    logic [uer_pkg::TRIG_W-1:0]   trig_len;
    logic [uer_pkg::TMO_MS_W-1:0] tmo_ms;
    logic [uer_pkg::TRIG_W-1:0]   trig_cnt;
    logic [COUNT_WIDTH-1:0]       tmo_cnt;
    logic [COUNT_WIDTH-1:0]       pulse_cnt;
    logic [uer_pkg::DIST_W-1:0]   dist_val;
    uer_pkg::result_t             range_expect_q[$];
    int                           word_idx;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t word %0d: %s", $realtime, word_idx, msg);
        fail_count = fail_count + 1;
    endtask

    function automatic uer_pkg::result_t ranging_tick(input logic start, input logic echo,
                                                      input logic rd);
        uer_pkg::phase_t  p;
        uer_pkg::result_t r;
        logic [63:0]      scaled;
        logic [63:0]      tmo_limit;
        p = ph;
        r = '0;
        if (p == uer_pkg::PH_WAIT_START || p == uer_pkg::PH_WAIT_END) begin
            if (tmo_cnt != '1) tmo_cnt = tmo_cnt + 1'b1;
        end
        if (p == uer_pkg::PH_WAIT_END) begin
            if (pulse_cnt != '1) pulse_cnt = pulse_cnt + 1'b1;
        end
        case (p)
            uer_pkg::PH_IDLE: begin
                if (start) begin
                    ph       = uer_pkg::PH_WAIT_START;
                    tmo_cnt  = '0;
                    trig_cnt = trig_len;
                end
            end
            uer_pkg::PH_WAIT_START: begin
                r.start_refused = start;
                if (echo) begin
                    pulse_cnt = '0;
                    ph        = uer_pkg::PH_WAIT_END;
                end
            end
            uer_pkg::PH_WAIT_END: begin
                r.start_refused = start;
                if (echo) begin
                    scaled   = 64'(pulse_cnt) * DIST_SCALE / DIST_DIVIDE;
                    dist_val = (scaled > 64'(uer_pkg::DIST_MAX)) ? uer_pkg::DIST_MAX
                                                                 : scaled[uer_pkg::DIST_W-1:0];
                    ph       = uer_pkg::PH_READY;
                end
            end
            default: begin
                r.start_refused = start;
                if (rd) ph = uer_pkg::PH_IDLE;
            end
        endcase
        // end edge beats the timeout on the same tick
        if ((p == uer_pkg::PH_WAIT_START || p == uer_pkg::PH_WAIT_END) &&
            (ph == uer_pkg::PH_WAIT_START || ph == uer_pkg::PH_WAIT_END)) begin
            tmo_limit = 64'(tmo_ms) * uer_pkg::US_PER_MS;
            if (64'(tmo_cnt) >= tmo_limit || tmo_cnt == '1) ph = uer_pkg::PH_IDLE;
        end
        r.trigger_out = (trig_cnt != '0);
        if (trig_cnt != '0) trig_cnt = trig_cnt - 1'b1;
        r.data_ready  = (ph == uer_pkg::PH_READY);
        r.distance_q8 = dist_val;
        r.phase       = ph;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        uer_pkg::result_t want;
        if (!aresetn) begin
            ph         = uer_pkg::PH_IDLE;
            trig_len   = uer_pkg::TRIG_LEN_RST;
            tmo_ms     = uer_pkg::TMO_MS_RST;
            trig_cnt   = '0;
            tmo_cnt    = '0;
            pulse_cnt  = '0;
            dist_val   = '0;
            word_idx   = 0;
            fail_count = 0;
            range_expect_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (range_expect_q.size() == 0) begin
                    report_mismatch($sformatf("word 0x%08h with nothing expected", m_tdata));
                end else begin
                    want = range_expect_q.pop_front();
                    if (m_tdata[0] !== want.trigger_out)
                        report_mismatch($sformatf("trigger_out got %0b expected %0b",
                                                  m_tdata[0], want.trigger_out));
                    if (m_tdata[1] !== want.start_refused)
                        report_mismatch($sformatf("start_refused got %0b expected %0b",
                                                  m_tdata[1], want.start_refused));
                    if (m_tdata[2] !== want.data_ready)
                        report_mismatch($sformatf("data_ready got %0b expected %0b",
                                                  m_tdata[2], want.data_ready));
                    if (m_tdata[uer_pkg::DIST_W+2:3] !== want.distance_q8)
                        report_mismatch($sformatf("distance_q8 got %0d expected %0d",
                                                  m_tdata[uer_pkg::DIST_W+2:3],
                                                  want.distance_q8));
                    if (m_tdata[uer_pkg::DIST_W+4:uer_pkg::DIST_W+3] !== want.phase)
                        report_mismatch($sformatf("phase got %0d expected %0d",
                                                  m_tdata[uer_pkg::DIST_W+4:uer_pkg::DIST_W+3],
                                                  want.phase));
                end
                word_idx = word_idx + 1;
            end
            if (s_tvalid && s_tready)
                range_expect_q.push_back(ranging_tick(s_tdata[0], s_tdata[1], s_tdata[2]));
            // a register write takes effect from the next word on
            if (cfg_wr_en) begin
                if (cfg_addr == uer_pkg::CFG_TRIGGER_LEN)
                    trig_len = cfg_wdata[uer_pkg::TRIG_W-1:0];
                else if (cfg_addr == uer_pkg::CFG_TIMEOUT_MS)
                    tmo_ms = cfg_wdata[uer_pkg::TMO_MS_W-1:0];
            end
        end
        expect_depth <= range_expect_q.size();
    end

endmodule

// ===== tb/sv/tb_ultrasonic_echo_ranging.sv =====
`timescale 1ns / 100ps

module tb_ultrasonic_echo_ranging;

    localparam int WDOG_LIMIT = 2000;

    // word layout: {read_ack, echo_edge, start_req}
    localparam logic [2:0] W_NONE  = 3'b000;
    localparam logic [2:0] W_START = 3'b001;
    localparam logic [2:0] W_ECHO  = 3'b010;
    localparam logic [2:0] W_READ  = 3'b100;

    localparam logic [2:0] DIRECTED [25] = '{
        W_NONE, W_ECHO, W_READ, W_ECHO | W_READ,
        W_START, W_START, W_START | W_READ, W_NONE,
        W_ECHO, W_START | W_READ, W_NONE, W_NONE, W_NONE,
        W_ECHO, W_ECHO, W_START | W_READ, W_READ,
        W_START | W_ECHO | W_READ, W_ECHO | W_READ, W_ECHO | W_START, W_READ,
        W_START, W_ECHO, W_ECHO, W_READ
    };

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [31:0]                    m_tdata;
    logic                           cfg_wr_en;
    logic [uer_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int expect_depth;
    int idle_cycles;
    int sink_hold;
    int cur_tmo;
    int words_sent;
    bit idle_en = 1'b1;

    ultrasonic_echo_ranging i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    uer_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .expect_depth (expect_depth)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!idle_en) begin
            m_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            sink_hold = $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [2:0] quiet_tick();
        return {($urandom_range(0, 3) == 0), 1'b0, ($urandom_range(0, 3) == 0)};
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(21, 400) : $urandom_range(0, 20);
    endfunction

    task automatic send_word(input logic [2:0] w);
        if (idle_en && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, w};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_quiet(input int n);
        repeat (n) send_word(quiet_tick());
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expect_depth != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_ranging(input int trig, input int tmo);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= uer_pkg::CFG_TRIGGER_LEN;
        cfg_wdata <= uer_pkg::CFG_DATA_W'(trig);
        @(posedge aclk);
        cfg_addr  <= uer_pkg::CFG_TIMEOUT_MS;
        cfg_wdata <= uer_pkg::CFG_DATA_W'(tmo);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        cur_tmo = tmo;
    endtask

    // end edge d ticks after the timeout tick; needs a nonzero timeout
    task automatic run_timeout_edge(input int d);
        int limit;
        int echo_at;
        limit   = cur_tmo * uer_pkg::US_PER_MS;
        echo_at = $urandom_range(1, 20);
        send_word(W_START);
        send_quiet(echo_at - 1);
        send_word(W_ECHO);
        send_quiet(limit + d - echo_at - 1);
        send_word(W_ECHO);
        send_word(W_READ);
    endtask

    task automatic run_ranging(input int budget);
        int first;
        int room;
        int kind;
        int limit;
        int span;
        int echo_at;
        first = words_sent;
        limit = cur_tmo * uer_pkg::US_PER_MS;
        while (words_sent - first < budget) begin
            room = budget - (words_sent - first);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise
                repeat ($urandom_range(1, 8)) send_word(3'($urandom_range(0, 7)));
            end else if (kind == 1 && limit + 8 <= room) begin
                // no end edge: run into the timeout
                span    = limit + $urandom_range(0, 3);
                echo_at = ($urandom_range(0, 1) == 1) ? $urandom_range(1, limit / 2 + 1) : -1;
                send_word(W_START);
                for (int k = 1; k <= span; k++)
                    send_word((k == echo_at) ? W_ECHO : quiet_tick());
            end else if (kind == 2 && cur_tmo >= 1 && limit + 8 <= room) begin
                // end edge around the timeout tick
                run_timeout_edge(int'($urandom_range(0, 2)) - 1);
            end else if (kind == 3) begin
                // broken: end edge missing
                send_word(W_START);
                send_quiet(pick_gap() % 8);
                send_word(W_ECHO);
                send_word(W_READ);
            end else begin
                span = pick_gap();
                if (span > room) span = room;
                send_word(W_START);
                send_quiet(pick_gap() % 8);
                send_word(W_ECHO);
                send_quiet(span);
                send_word(W_ECHO);
                send_quiet($urandom_range(0, 3));
                send_word(W_READ);
            end
        end
        // back to idle from any phase
        send_word(W_ECHO);
        send_word(W_ECHO);
        send_word(W_READ);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        sink_hold = 0;
        idle_cycles = 0;
        words_sent  = 0;
        cur_tmo   = 60;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) send_word(DIRECTED[i]);
        drain_results();

        program_ranging(1, 1);
        run_ranging(40);
        drain_results();

        program_ranging(255, 0);
        run_ranging(40);
        drain_results();

        program_ranging(0, 2);
        run_ranging(40);
        drain_results();

        program_ranging(255, 1000);
        run_ranging(40);
        drain_results();

        idle_en <= 1'b0;
        program_ranging($urandom_range(2, 254), 1);
        run_timeout_edge(0);
        run_ranging(30);
        drain_results();

        if (fail_count == 0 && expect_depth == 0) begin
            $display("Regression PASS");
        end else begin
            if (expect_depth != 0) $display("%0d expected words never arrived", expect_depth);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
